@@ rtl/chained_hash_set_macros.svh @@
// ---------------------------------------------------------------------------
// Chained hash set assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH

// same-cycle implication
`define CHS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/chs_pkg.sv @@
// ---------------------------------------------------------------------------
// Chained hash set package
// Sizes, codes, job word and the byte-wise remainder step.
// ---------------------------------------------------------------------------
package chs_pkg;

    localparam int BUCKET_COUNT = 101;
    localparam int NODE_COUNT   = 1024;

    localparam int KEY_W        = 32;
    localparam int KEY_BYTES    = KEY_W / 8;
    localparam int BYTE_CNT_W   = $clog2(KEY_BYTES);
    localparam int BKT_W        = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int NODE_W       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PTR_W        = $clog2(NODE_COUNT + 1);
    localparam int SUM_W        = $clog2(BUCKET_COUNT + 256);
    localparam int REDUCE_STEPS = (BUCKET_COUNT + 255) / BUCKET_COUNT;
    localparam int OUT_TDATA_W  = 8;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_HEAD,
        B_WALK
    } back_state_t;

    typedef logic [BKT_W-1:0] bucket_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        bucket_t          bucket;
    } job_t;

    typedef bucket_t shift_tab_t [BUCKET_COUNT];

    // (r * 256) mod BUCKET_COUNT for every remainder r
    function automatic shift_tab_t build_shift_tab();
        shift_tab_t tab;
        for (int i = 0; i < BUCKET_COUNT; i++)
        begin
            tab[i] = BKT_W'((i * 256) % BUCKET_COUNT);
        end
        return tab;
    endfunction

    localparam shift_tab_t SHIFT_TAB = build_shift_tab();

    // fold one more key byte into a running remainder
    function automatic bucket_t mod_step(bucket_t r, logic [7:0] b);
        logic [SUM_W-1:0] t;
        t = SUM_W'(SHIFT_TAB[r]) + SUM_W'(b);
        for (int i = 0; i < REDUCE_STEPS; i++)
        begin
            if (t >= SUM_W'(BUCKET_COUNT))
            begin
                t = t - SUM_W'(BUCKET_COUNT);
            end
        end
        return BKT_W'(t);
    endfunction

endpackage

@@ rtl/chs_front.sv @@
// ---------------------------------------------------------------------------
// Chained hash set front end
// Accepts a word and computes its bucket one key byte per cycle.
// ---------------------------------------------------------------------------
module chs_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_op,
    input  logic [chs_pkg::KEY_W-1:0] in_key,
    output logic                      push_valid,
    input  logic                      push_ready,
    output chs_pkg::job_t             push_job
);

    chs_pkg::front_state_t            state_reg;
    chs_pkg::front_state_t            state_next;
    chs_pkg::op_t                     op_reg;
    logic [chs_pkg::KEY_W-1:0]        key_reg;
    logic [chs_pkg::KEY_W-1:0]        shift_reg;
    chs_pkg::bucket_t                 rem_reg;
    logic [chs_pkg::BYTE_CNT_W-1:0]   cnt_reg;
    logic                             take;
    logic                             last_byte;

    assign take      = in_valid && in_ready;
    assign last_byte = (cnt_reg == chs_pkg::BYTE_CNT_W'(chs_pkg::KEY_BYTES - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chs_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = chs_pkg::F_REDUCE;
                end
            end
            chs_pkg::F_REDUCE:
            begin
                if (last_byte)
                begin
                    state_next = chs_pkg::F_PUSH;
                end
            end
            chs_pkg::F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = chs_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = chs_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == chs_pkg::F_IDLE);
        push_valid = (state_reg == chs_pkg::F_PUSH);
        push_job   = '{op: op_reg, key: key_reg, bucket: rem_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chs_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // key bytes enter most significant first
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= chs_pkg::op_t'(in_op);
            key_reg   <= in_key;
            shift_reg <= in_key;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (state_reg == chs_pkg::F_REDUCE)
        begin
            rem_reg   <= chs_pkg::mod_step(rem_reg, shift_reg[chs_pkg::KEY_W-1 -: 8]);
            shift_reg <= shift_reg << 8;
            cnt_reg   <= cnt_reg + chs_pkg::BYTE_CNT_W'(1);
        end
    end

endmodule

@@ rtl/chs_fifo.sv @@
// ---------------------------------------------------------------------------
// Chained hash set job queue
// Short queue of classified jobs between the front end and the back end.
// ---------------------------------------------------------------------------
module chs_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  chs_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output chs_pkg::job_t pop_job
);

    chs_pkg::job_t                 mem_reg [chs_pkg::QUEUE_DEPTH];
    logic [chs_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [chs_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [chs_pkg::QCNT_W-1:0]    count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != chs_pkg::QCNT_W'(chs_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == chs_pkg::QPTR_W'(chs_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + chs_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == chs_pkg::QPTR_W'(chs_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + chs_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + chs_pkg::QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - chs_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/chs_back.sv @@
// ---------------------------------------------------------------------------
// Chained hash set back end
// Holds bucket heads and the node pool, links inserts and walks chains.
// ---------------------------------------------------------------------------
`include "chained_hash_set_macros.svh"

module chs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  chs_pkg::job_t       job,
    output logic                out_valid,
    input  logic                out_ready,
    output chs_pkg::status_t    out_status
);

    chs_pkg::back_state_t             state_reg;
    chs_pkg::back_state_t             state_next;
    chs_pkg::job_t                    job_reg;
    logic [chs_pkg::PTR_W-1:0]        used_reg;
    logic [chs_pkg::BUCKET_COUNT-1:0] head_vld_reg;

    logic [chs_pkg::PTR_W-1:0]        head_mem [chs_pkg::BUCKET_COUNT];
    logic [chs_pkg::PTR_W-1:0]        head_rd_reg;
    logic                             head_rd_vld_reg;
    logic [chs_pkg::KEY_W-1:0]        node_key_mem [chs_pkg::NODE_COUNT];
    logic [chs_pkg::PTR_W-1:0]        node_link_mem [chs_pkg::NODE_COUNT];
    logic [chs_pkg::KEY_W-1:0]        node_key_rd_reg;
    logic [chs_pkg::PTR_W-1:0]        node_link_rd_reg;

    logic                             out_valid_reg;
    chs_pkg::status_t                 out_status_reg;

    logic                             slot_free;
    logic                             take;
    logic [chs_pkg::PTR_W-1:0]        head_cur;
    logic                             pool_full;
    logic                             link_we;
    logic                             node_rd;
    logic [chs_pkg::NODE_W-1:0]       node_rd_addr;
    logic                             res_load;
    chs_pkg::status_t                 res_status;

    assign slot_free  = !out_valid_reg || out_ready;
    assign job_ready  = (state_reg == chs_pkg::B_IDLE) && slot_free;
    assign take       = job_valid && job_ready;
    assign head_cur   = head_rd_vld_reg ? head_rd_reg : '0;
    assign pool_full  = (used_reg == chs_pkg::PTR_W'(chs_pkg::NODE_COUNT));
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        link_we      = 1'b0;
        node_rd      = 1'b0;
        node_rd_addr = '0;
        res_load     = 1'b0;
        res_status   = chs_pkg::ST_OK;
        unique case (state_reg)
            chs_pkg::B_IDLE:
            begin
            end
            chs_pkg::B_HEAD:
            begin
                if (job_reg.op == chs_pkg::OP_INSERT)
                begin
                    res_load = 1'b1;
                    if (pool_full)
                    begin
                        res_status = chs_pkg::ST_FULL;
                    end
                    else
                    begin
                        link_we = 1'b1;
                    end
                end
                else if (head_cur == '0)
                begin
                    res_load   = 1'b1;
                    res_status = chs_pkg::ST_MISS;
                end
                else
                begin
                    node_rd      = 1'b1;
                    node_rd_addr = chs_pkg::NODE_W'(head_cur - chs_pkg::PTR_W'(1));
                end
            end
            chs_pkg::B_WALK:
            begin
                // links always point to older nodes, so a chain ends before the pool does
                if (node_key_rd_reg == job_reg.key)
                begin
                    res_load = 1'b1;
                end
                else if (node_link_rd_reg == '0)
                begin
                    res_load   = 1'b1;
                    res_status = chs_pkg::ST_MISS;
                end
                else
                begin
                    node_rd      = 1'b1;
                    node_rd_addr = chs_pkg::NODE_W'(node_link_rd_reg - chs_pkg::PTR_W'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chs_pkg::B_IDLE:
            begin
                if (take)
                begin
                    state_next = chs_pkg::B_HEAD;
                end
            end
            chs_pkg::B_HEAD, chs_pkg::B_WALK:
            begin
                state_next = res_load ? chs_pkg::B_IDLE : chs_pkg::B_WALK;
            end
            default:
            begin
                state_next = chs_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chs_pkg::B_IDLE;
            used_reg      <= '0;
            head_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (link_we)
            begin
                used_reg                     <= used_reg + chs_pkg::PTR_W'(1);
                head_vld_reg[job_reg.bucket] <= 1'b1;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job;
        end
        if (res_load)
        begin
            out_status_reg <= res_status;
        end
    end

    // bucket heads: written when linking, read once per job
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            head_mem[job_reg.bucket] <= used_reg + chs_pkg::PTR_W'(1);
        end
        if (take)
        begin
            head_rd_reg     <= head_mem[job.bucket];
            head_rd_vld_reg <= head_vld_reg[job.bucket];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            node_key_mem[used_reg[chs_pkg::NODE_W-1:0]]  <= job_reg.key;
            node_link_mem[used_reg[chs_pkg::NODE_W-1:0]] <= head_cur;
        end
        if (node_rd)
        begin
            node_key_rd_reg  <= node_key_mem[node_rd_addr];
            node_link_rd_reg <= node_link_mem[node_rd_addr];
        end
    end

    `CHS_ASSERT_IMPL(a_used_bound, 1'b1, used_reg <= chs_pkg::PTR_W'(chs_pkg::NODE_COUNT), "node pool count overrun")
    `CHS_ASSERT_IMPL(a_result_slot, res_load, !out_valid_reg || out_ready, "result overwrites a pending word")
    `CHS_ASSERT_NEXT(a_link_advances, link_we, used_reg == $past(used_reg) + chs_pkg::PTR_W'(1), "insert did not take a node")

endmodule

@@ rtl/chained_hash_set.sv @@
// ---------------------------------------------------------------------------
// Chained hash set
// Insert and lookup of 32-bit keys in a hash table with separate chaining.
// ---------------------------------------------------------------------------
// Each input word is an insert (tuser 0) or a lookup (tuser 1) of a key and
// gives one output word with a status: 0 done or found, 1 not found, 2 node
// pool full. The front end reduces the key modulo the bucket count, one byte
// per cycle, then hands the job to a two-entry queue, and takes no new word
// until that hand-off is done. The back end reads the bucket head for each
// job and, for a lookup, reads the node memory once per chain node visited.
// Bucket heads are empty right after reset, with no clear sweep; inserts never
// check for duplicates and nodes are never freed.
module chained_hash_set (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [chs_pkg::KEY_W-1:0]       s_axis_tdata,   // [31:0] key
    input  logic                            s_axis_tuser,   // [0] op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [chs_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [1:0] status, [7:2] zero
);

    logic             push_valid;
    logic             push_ready;
    chs_pkg::job_t    push_job;
    logic             pop_valid;
    logic             pop_ready;
    chs_pkg::job_t    pop_job;
    chs_pkg::status_t status;

    chs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_key     (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    chs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    chs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (pop_valid),
        .job_ready  (pop_ready),
        .job        (pop_job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status)
    );

    assign m_axis_tdata = {(chs_pkg::OUT_TDATA_W - 2)'(0), status};

endmodule

@@ sim/chained_hash_set_test.sv @@
// ---------------------------------------------------------------------------
// Chained hash set testbench
// Drives insert and lookup words through the stream ports with random gaps
// and stalls, predicts untyped statuses from a private copy of the bucket
// chains and the node pool, and compares each output word in order.
// ---------------------------------------------------------------------------
module chained_hash_set_test;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RAND_WORDS   = 600;
    localparam int HOT_COUNT    = 4;

    typedef struct {
        chs_pkg::op_t     op;
        logic [31:0]      key;
        bit               typed;
        chs_pkg::status_t want;
    } probe_t;

    // typed rows carry their status; the others take the predicted one
    localparam int DIR_ROWS = 22;
    probe_t dir_tab [DIR_ROWS] = '{
        '{chs_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, chs_pkg::ST_MISS},
        '{chs_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, chs_pkg::ST_MISS},
        '{chs_pkg::OP_INSERT, 32'h0000_0000, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'h0000_0000, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'd101,       1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'd202,       1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'd303,       1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'h0000_0000, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'h0000_0000, 1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'd101,       1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'h8000_0000, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'h8000_0000, 1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'h5555_5555, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'hAAAA_AAAA, 1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'hFFFF_FF9A, 1'b0, chs_pkg::ST_OK},
        '{chs_pkg::OP_INSERT, 32'd100,       1'b1, chs_pkg::ST_OK},
        '{chs_pkg::OP_LOOKUP, 32'd100,       1'b0, chs_pkg::ST_OK}
    };

    int unsigned hot_bucket [HOT_COUNT] = '{0, 1, 57, 100};

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [chs_pkg::KEY_W-1:0]       s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [chs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // private copy of the table: heads and links hold node index + 1, 0 is empty
    int unsigned chain_head [chs_pkg::BUCKET_COUNT];
    logic [31:0] slot_key   [chs_pkg::NODE_COUNT];
    int unsigned slot_next  [chs_pkg::NODE_COUNT];
    int unsigned slots_taken;

    chs_pkg::status_t status_q [$];
    logic [31:0]      kept_keys [$];
    int               err_count   = 0;
    int               sent_words;
    int               taken_words = 0;
    int               idle_cycles = 0;

    chained_hash_set dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // insert or look up one key in the private table
    function automatic chs_pkg::status_t apply_to_table(chs_pkg::op_t op, logic [31:0] key);
        int unsigned bkt;
        int unsigned cur;
        int unsigned steps;
        bkt = key % 32'(chs_pkg::BUCKET_COUNT);
        if (op == chs_pkg::OP_INSERT)
        begin
            if (slots_taken >= chs_pkg::NODE_COUNT)
            begin
                return chs_pkg::ST_FULL;
            end
            slot_key[slots_taken]  = key;
            slot_next[slots_taken] = chain_head[bkt];
            chain_head[bkt]        = slots_taken + 1;
            slots_taken++;
            return chs_pkg::ST_OK;
        end
        cur   = chain_head[bkt];
        steps = 0;
        while (cur != 0 && cur <= chs_pkg::NODE_COUNT && steps < chs_pkg::NODE_COUNT)
        begin
            if (slot_key[cur-1] == key)
            begin
                return chs_pkg::ST_OK;
            end
            cur = slot_next[cur-1];
            steps++;
        end
        return chs_pkg::ST_MISS;
    endfunction

    // zero gaps for one stretch of 40 words out of every 160
    function automatic int pick_gap(int count, int burst_phase);
        if ((count / 40) % 4 == burst_phase)
        begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [31:0] hot_key();
        longint unsigned k;
        k = 64'd101 * $urandom_range(0, 42524427) + hot_bucket[$urandom_range(0, HOT_COUNT-1)];
        return k[31:0];
    endfunction

    task automatic send_word(chs_pkg::op_t op, logic [31:0] key, bit typed,
                             chs_pkg::status_t want);
        int               gap;
        chs_pkg::status_t got;
        gap = pick_gap(sent_words, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        got = apply_to_table(op, key);
        if (got == chs_pkg::ST_OK && op == chs_pkg::OP_INSERT)
        begin
            kept_keys.push_back(key);
        end
        status_q.push_back(typed ? want : got);
        sent_words++;
    endtask

    // receiver: random stalls, then compare the word with the oldest status
    initial
    begin
        int               gap;
        chs_pkg::status_t want;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap(taken_words, 1);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            taken_words++;
            if (status_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %0h", m_axis_tdata));
            end
            else
            begin
                want = status_q.pop_front();
                if (m_axis_tdata[1:0] !== want)
                begin
                    report_mismatch($sformatf("word %0d status %0d, want %0d",
                                              taken_words, m_axis_tdata[1:0], want));
                end
                if (m_axis_tdata[chs_pkg::OUT_TDATA_W-1:2] !== '0)
                begin
                    report_mismatch($sformatf("word %0d padding %0h", taken_words,
                                              m_axis_tdata[chs_pkg::OUT_TDATA_W-1:2]));
                end
            end
        end
    end

    // end the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        int               rand_words;
        int unsigned      pick;
        chs_pkg::op_t     op;
        logic [31:0]      key;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        sent_words  = 0;
        slots_taken = 0;
        foreach (chain_head[i]) chain_head[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_word(dir_tab[i].op, dir_tab[i].key, dir_tab[i].typed, dir_tab[i].want);
        end

        // insert-heavy while the pool has room, then an even mix
        rand_words = 0;
        while (rand_words < RAND_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (slots_taken < chs_pkg::NODE_COUNT)
            begin
                op = (pick < 75) ? chs_pkg::OP_INSERT : chs_pkg::OP_LOOKUP;
            end
            else
            begin
                op = (pick < 50) ? chs_pkg::OP_INSERT : chs_pkg::OP_LOOKUP;
            end
            pick = $urandom_range(0, 99);
            if (op == chs_pkg::OP_INSERT)
            begin
                if (pick < 40)
                begin
                    key = hot_key();
                end
                else if (pick < 50 && kept_keys.size() > 0)
                begin
                    key = kept_keys[$urandom_range(0, kept_keys.size()-1)];
                end
                else
                begin
                    key = $urandom;
                end
            end
            else
            begin
                if (pick < 50 && kept_keys.size() > 0)
                begin
                    key = kept_keys[$urandom_range(0, kept_keys.size()-1)];
                end
                else if (pick < 75)
                begin
                    key = hot_key();
                end
                else
                begin
                    key = $urandom;
                end
            end
            send_word(op, key, 1'b0, chs_pkg::ST_OK);
            rand_words++;
        end
        s_axis_tvalid <= 1'b0;

        while (status_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
